// ----- rtl/qqd_pkg.sv -----
// shared types and constants of the quantized quaternion dequantizer
package qqd_pkg;

  localparam int unsigned FRAC_BITS_DEF = 28;
  localparam int unsigned LANES = 4;   // x, y, z, w dividers
  localparam int unsigned AXES  = 3;

  typedef enum logic {
    KIND_TRANSLATION = 1'b0,
    KIND_ROTATION    = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic        [15:0] quant_x;
    logic        [15:0] quant_y;
    logic        [15:0] quant_z;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [31:0] step_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_w;
  } out_t;

endpackage

// ----- rtl/quantized_quaternion_dequantizer.sv -----
// top level: pipelined dequantizer with inverse stereographic quaternion mapping
//
// usage
//   in channel: in_valid_i / in_stall_o with in_data_i; a transfer happens at a
//   rising edge with valid high and stall low. each transfer carries a kind
//   (translation or rotation), three 16-bit quanta and per-axis step/offset.
//   out channel: out_valid_o / out_stall_i with out_data_o, one result per item.
// throughput: one item per cycle unless the output is held; the stages are
//   dequantize, square, sum, divider setup, FRAC_BITS + 1 restoring divider
//   steps (one quotient bit each, all four lanes side by side) and the output
//   register; at the default FRAC_BITS of 28 results are signed Q3.28
// stall: when the output register holds a result and out_stall_i is high the
//   whole pipeline freezes and in_stall_o rises; nothing is dropped or repeated
// reset: rst_ni is asynchronous active low and clears every stage valid bit;
//   the pipeline comes up empty and ready
// results are signed Q(31-FRAC_BITS).FRAC_BITS; translation w is zero
module quantized_quaternion_dequantizer #(
  parameter int unsigned FRAC_BITS = qqd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qqd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qqd_pkg::out_t out_data_o
);

  localparam int unsigned NDIV = FRAC_BITS + 1;        // quotient bits
  localparam logic [63:0] ONE_SQ = 64'(1) << (2 * FRAC_BITS);

  function automatic logic signed [31:0] sat32(input logic signed [49:0] val);
    logic signed [31:0] res;
    if (val > 50'sh0_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (val < -50'sh0_0000_8000_0000) begin
      res = -32'sh8000_0000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

  // whole pipeline moves together unless the output is held
  logic advance;
  logic out_vld_q;
  assign advance    = !(out_vld_q && out_stall_i);
  assign in_stall_o = !advance;

  // ---------------------------------------------------------------- stage 1
  // dequantize: v = sat(q * step + offset)
  logic [15:0]        quant [qqd_pkg::AXES];
  logic signed [31:0] step  [qqd_pkg::AXES];
  logic signed [31:0] offs  [qqd_pkg::AXES];
  logic signed [31:0] v1_d  [qqd_pkg::AXES];

  assign quant[0] = in_data_i.quant_x;
  assign quant[1] = in_data_i.quant_y;
  assign quant[2] = in_data_i.quant_z;
  assign step[0]  = in_data_i.step_x;
  assign step[1]  = in_data_i.step_y;
  assign step[2]  = in_data_i.step_z;
  assign offs[0]  = in_data_i.offset_x;
  assign offs[1]  = in_data_i.offset_y;
  assign offs[2]  = in_data_i.offset_z;

  for (genvar a = 0; a < qqd_pkg::AXES; a++) begin : g_deq
    logic signed [48:0] prod;
    logic signed [49:0] sum;
    assign prod    = $signed({1'b0, quant[a]}) * step[a];
    assign sum     = {prod[48], prod} + {{18{offs[a][31]}}, offs[a]};
    assign v1_d[a] = sat32(sum);
  end

  logic               s1_vld_q;
  qqd_pkg::kind_e     s1_kind_q;
  logic signed [31:0] v1_q [qqd_pkg::AXES];

  // ---------------------------------------------------------------- stage 2
  // squares of the saturated components
  logic               s2_vld_q;
  qqd_pkg::kind_e     s2_kind_q;
  logic signed [31:0] v2_q [qqd_pkg::AXES];
  logic [63:0]        sq_q [qqd_pkg::AXES];
  logic [63:0]        sq_d [qqd_pkg::AXES];

  for (genvar a = 0; a < qqd_pkg::AXES; a++) begin : g_sq
    logic signed [63:0] prod;
    assign prod    = v1_q[a] * v1_q[a];
    assign sq_d[a] = prod;
  end

  // ---------------------------------------------------------------- stage 3
  // square sum s, exact with 2*FRAC_BITS fraction bits
  logic               s3_vld_q;
  qqd_pkg::kind_e     s3_kind_q;
  logic signed [31:0] v3_q [qqd_pkg::AXES];
  logic [63:0]        ssum_q;
  logic [63:0]        ssum_d;
  assign ssum_d = sq_q[0] + sq_q[1] + sq_q[2];

  // ---------------------------------------------------------------- stage 4
  // divider setup: denominator 1+s, w numerator |1-s|, first partial remainders
  logic [63:0]      den_d;
  logic [63:0]      rem_d  [qqd_pkg::LANES];
  logic [NDIV-1:0]  pend_d [qqd_pkg::LANES];
  logic             neg_d  [qqd_pkg::LANES];
  logic             wneg;
  logic [63:0]      wmag;

  assign den_d = ssum_q + ONE_SQ;
  assign wneg  = ssum_q > ONE_SQ;
  assign wmag  = wneg ? (ssum_q - ONE_SQ) : (ONE_SQ - ssum_q);

  for (genvar a = 0; a < qqd_pkg::AXES; a++) begin : g_init
    logic [31:0] mag;
    assign mag       = v3_q[a][31] ? 32'(-v3_q[a]) : v3_q[a];
    // numerator 2|v| << 2F; dropping the low F+1 bits leaves |v| << F
    assign rem_d[a]  = 64'(mag) << FRAC_BITS;
    assign pend_d[a] = '0;
    assign neg_d[a]  = v3_q[a][31];
  end
  // numerator |1-s| << F; its low F+1 bits are wmag[0] followed by zeros
  assign rem_d[3]  = wmag >> 1;
  assign pend_d[3] = {wmag[0], {(NDIV-1){1'b0}}};
  assign neg_d[3]  = wneg;

  // divider pipeline, index 0 is the setup register
  logic               dv_vld_q  [NDIV+1];
  qqd_pkg::kind_e     dv_kind_q [NDIV+1];
  logic signed [31:0] dv_v_q    [NDIV+1][qqd_pkg::AXES];
  logic [63:0]        dv_den_q  [NDIV+1];
  logic [63:0]        dv_rem_q  [NDIV+1][qqd_pkg::LANES];
  logic [NDIV-1:0]    dv_pend_q [NDIV+1][qqd_pkg::LANES];
  logic [NDIV-1:0]    dv_quo_q  [NDIV+1][qqd_pkg::LANES];
  logic               dv_neg_q  [NDIV+1][qqd_pkg::LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (advance) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      dv_vld_q[0] <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_kind_q    <= in_data_i.kind;
      s2_kind_q    <= s1_kind_q;
      s3_kind_q    <= s2_kind_q;
      dv_kind_q[0] <= s3_kind_q;
      ssum_q       <= ssum_d;
      dv_den_q[0]  <= den_d;
      for (int a = 0; a < qqd_pkg::AXES; a++) begin
        v1_q[a]      <= v1_d[a];
        v2_q[a]      <= v1_q[a];
        sq_q[a]      <= sq_d[a];
        v3_q[a]      <= v2_q[a];
        dv_v_q[0][a] <= v3_q[a];
      end
      for (int l = 0; l < qqd_pkg::LANES; l++) begin
        dv_rem_q[0][l]  <= rem_d[l];
        dv_pend_q[0][l] <= pend_d[l];
        dv_quo_q[0][l]  <= '0;
        dv_neg_q[0][l]  <= neg_d[l];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [63:0]     rem_nx  [qqd_pkg::LANES];
    logic [NDIV-1:0] quo_nx  [qqd_pkg::LANES];
    logic [NDIV-1:0] pend_nx [qqd_pkg::LANES];

    for (genvar l = 0; l < qqd_pkg::LANES; l++) begin : g_lane
      logic [64:0] trial;
      logic        fits;
      assign trial       = {dv_rem_q[k][l], dv_pend_q[k][l][NDIV-1]};
      assign fits        = trial >= {1'b0, dv_den_q[k]};
      assign rem_nx[l]   = fits ? 64'(trial - {1'b0, dv_den_q[k]}) : trial[63:0];
      assign quo_nx[l]   = {dv_quo_q[k][l][NDIV-2:0], fits};
      assign pend_nx[l]  = dv_pend_q[k][l] << 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (advance) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        dv_kind_q[k+1] <= dv_kind_q[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        for (int a = 0; a < qqd_pkg::AXES; a++) begin
          dv_v_q[k+1][a] <= dv_v_q[k][a];
        end
        for (int l = 0; l < qqd_pkg::LANES; l++) begin
          dv_rem_q[k+1][l]  <= rem_nx[l];
          dv_pend_q[k+1][l] <= pend_nx[l];
          dv_quo_q[k+1][l]  <= quo_nx[l];
          dv_neg_q[k+1][l]  <= dv_neg_q[k][l];
        end
      end
    end
  end

  // ---------------------------------------------------------------- output
  // quotients are at most 2^F, so sign and 32-bit range never overflow
  logic signed [31:0] quat [qqd_pkg::LANES];
  for (genvar l = 0; l < qqd_pkg::LANES; l++) begin : g_sign
    logic [31:0] mag32;
    assign mag32   = 32'(dv_quo_q[NDIV][l]);
    assign quat[l] = dv_neg_q[NDIV][l] ? -mag32 : mag32;
  end

  qqd_pkg::out_t  out_d;
  qqd_pkg::out_t  out_q;
  qqd_pkg::kind_e out_kind_q;

  always_comb begin
    case (dv_kind_q[NDIV])
      qqd_pkg::KIND_ROTATION: begin
        out_d.res_x = quat[0];
        out_d.res_y = quat[1];
        out_d.res_z = quat[2];
        out_d.res_w = quat[3];
      end
      default: begin
        out_d.res_x = dv_v_q[NDIV][0];
        out_d.res_y = dv_v_q[NDIV][1];
        out_d.res_z = dv_v_q[NDIV][2];
        out_d.res_w = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= dv_vld_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q      <= out_d;
      out_kind_q <= dv_kind_q[NDIV];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  localparam logic signed [31:0] UNIT = 32'sd1 <<< FRAC_BITS;

  // translation results carry a zero w
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == qqd_pkg::KIND_TRANSLATION) |-> out_q.res_w == '0)
    else $error("translation result with nonzero w");

  // quaternion w and x components stay within the unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == qqd_pkg::KIND_ROTATION) |->
      (out_q.res_w <= UNIT && out_q.res_w >= -UNIT &&
       out_q.res_x <= UNIT && out_q.res_x >= -UNIT))
    else $error("quaternion component beyond unit range");

  // a held output freezes the divider pipeline too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> $stable(dv_vld_q[NDIV]) && $stable(s1_vld_q))
    else $error("pipeline moved while output held");
`endif

endmodule
